[rtl/hbrp_pkg.sv]
package hbrp_pkg;

   localparam int HBRP_MAX_HEADER_BYTES = 256;

   // Depth of the queue between the byte parser and the range resolver
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_VALID   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_UNSAT   = 2'd3;

   localparam logic [2:0] PREFIX_LEN = 3'd6;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_EQUAL = 8'h3d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam logic [1:0] DASH_NONE = 2'd0;
   localparam logic [1:0] DASH_ONE  = 2'd1;
   localparam logic [1:0] DASH_MANY = 2'd2;

   // Parse summary of one finished header, handed from front to back
   typedef struct packed {
      logic        overlong;
      logic        started;
      logic        prefix_ok;
      logic        comma;
      logic [1:0]  dash_count;
      logic [63:0] first_value;
      logic        first_seen;
      logic        first_bad;
      logic [63:0] second_value;
      logic        second_seen;
      logic        second_bad;
      logic [63:0] total;
   } entry_type;

   typedef struct packed {
      logic [63:0] value;
      logic        bad;
   } num_type;

   // Lower-case character expected at each position of "bytes="
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h62;
         3'd1:    ch = 8'h79;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h65;
         3'd4:    ch = 8'h73;
         default: ch = CHAR_EQUAL;
      endcase
      return ch;
   endfunction

   // Append one decimal character; mark bad on a non-digit or on overflow
   function automatic num_type add_digit(input logic [63:0] value, input logic bad,
                                         input logic [7:0] ch);
      num_type    res;
      logic [67:0] ext;
      logic [67:0] sum;
      res.value = value;
      res.bad   = bad;
      ext = {4'b0, value};
      sum = (ext << 3) + (ext << 1) + {60'b0, ch - CHAR_ZERO};
      if (!bad) begin
         if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
            res.bad = 1'b1;
         end else if (sum[67:64] != 4'b0) begin
            res.bad = 1'b1;
         end else begin
            res.value = sum[63:0];
         end
      end
      return res;
   endfunction

endpackage

[rtl/http_byte_range_parser_core.sv]
// Single-range HTTP Range header parser. Feed the header value one byte per
// transaction on the req_ channel, with req_last_byte marking the end and
// req_total_size carrying the file size on that last transaction; a transaction
// with req_byte_present low adds no character. One rsp_ transaction follows each
// header: status none, valid (start and length), invalid or unsatisfiable.
// Leading and trailing blanks are dropped, the prefix "bytes=" is matched without
// regard to case, and headers longer than MAX_HEADER_BYTES report none. The
// parser takes one byte every cycle while req_stall is low, with no gaps between
// headers. After the last byte is accepted, the accepting edge writes the parse
// summary into a two-entry queue, then a classify stage does the 64-bit compares,
// then an output stage does the 64-bit subtract. req_stall rises only while that
// queue is full.
module http_byte_range_parser_core #(
   parameter int MAX_HEADER_BYTES = hbrp_pkg::HBRP_MAX_HEADER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_header_byte,
   input  logic        req_byte_present,
   input  logic        req_last_byte,
   input  logic [63:0] req_total_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_range_status,
   output logic [63:0] rsp_range_start,
   output logic [63:0] rsp_range_length
);
   import hbrp_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_valid;
   entry_type push_entry;
   entry_type head_entry;

   // front: walk the header bytes and track the parse state
   hbrp_front #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_header_byte  (req_header_byte),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .req_total_size   (req_total_size),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   // hold finished headers so either side can stall on its own
   hbrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (head_entry),
      .pop        (q_pop)
   );

   // back: resolve status, start and length against the file size
   hbrp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_range_status (rsp_range_status),
      .rsp_range_start  (rsp_range_start),
      .rsp_range_length (rsp_range_length)
   );

endmodule

[rtl/hbrp_front.sv]
module hbrp_front #(
   parameter int MAX_HEADER_BYTES = hbrp_pkg::HBRP_MAX_HEADER_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_header_byte,
   input  logic                req_byte_present,
   input  logic                req_last_byte,
   input  logic [63:0]         req_total_size,
   input  logic                q_full,
   output logic                q_push,
   output hbrp_pkg::entry_type q_entry
);
   import hbrp_pkg::*;

   localparam int CountWidth = $clog2(MAX_HEADER_BYTES + 2);
   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_HEADER_BYTES);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [2:0]  ppos_ff, ppos_in;
   logic        pfail_ff, pfail_in;
   logic [1:0]  dash_ff, dash_in;
   logic        comma_ff, comma_in;
   logic        pend_ff, pend_in;
   logic [63:0] fval_ff, fval_in;
   logic        fseen_ff, fseen_in;
   logic        fbad_ff, fbad_in;
   logic [63:0] sval_ff, sval_in;
   logic        sseen_ff, sseen_in;
   logic        sbad_ff, sbad_in;

   logic       accept;
   logic       blank;
   logic       started;
   logic       prefix_hit;
   logic [7:0] want;
   num_type    num;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign blank     = (req_header_byte == CHAR_SPACE) || (req_header_byte == CHAR_TAB);
   assign started   = pfail_ff || (ppos_ff != 3'd0);
   assign want      = prefix_char(ppos_ff);
   assign prefix_hit = (want == CHAR_EQUAL) ? (req_header_byte == CHAR_EQUAL)
                                            : ((req_header_byte | CASE_BIT) == want);

   always_comb begin
      count_in = count_ff;
      ppos_in  = ppos_ff;
      pfail_in = pfail_ff;
      dash_in  = dash_ff;
      comma_in = comma_ff;
      pend_in  = pend_ff;
      fval_in  = fval_ff;
      fseen_in = fseen_ff;
      fbad_in  = fbad_ff;
      sval_in  = sval_ff;
      sseen_in = sseen_ff;
      sbad_in  = sbad_ff;
      num      = '0;
      if (accept && req_byte_present) begin
         if (count_ff <= MaxCount) begin
            count_in = count_ff + 1'b1;
         end
         if (blank) begin
            if (started) begin
               pend_in = 1'b1;
            end
         end else begin
            // inner blank run acts as one non-digit character
            if (pend_ff && !pfail_ff) begin
               if (ppos_ff < PREFIX_LEN) begin
                  pfail_in = 1'b1;
               end else if (dash_ff == DASH_NONE) begin
                  fseen_in = 1'b1;
                  fbad_in  = 1'b1;
               end else if (dash_ff == DASH_ONE) begin
                  sseen_in = 1'b1;
                  sbad_in  = 1'b1;
               end
            end
            pend_in = 1'b0;
            if (!pfail_in) begin
               if (ppos_ff < PREFIX_LEN) begin
                  if (prefix_hit) begin
                     ppos_in = ppos_ff + 3'd1;
                  end else begin
                     pfail_in = 1'b1;
                  end
               end else if (req_header_byte == CHAR_COMMA) begin
                  comma_in = 1'b1;
               end else if (req_header_byte == CHAR_DASH) begin
                  if (dash_ff != DASH_MANY) begin
                     dash_in = dash_ff + 2'd1;
                  end
               end else if (dash_ff == DASH_NONE) begin
                  num      = add_digit(fval_ff, fbad_in, req_header_byte);
                  fseen_in = 1'b1;
                  fval_in  = num.value;
                  fbad_in  = num.bad;
               end else if (dash_ff == DASH_ONE) begin
                  num      = add_digit(sval_ff, sbad_in, req_header_byte);
                  sseen_in = 1'b1;
                  sval_in  = num.value;
                  sbad_in  = num.bad;
               end
            end
         end
      end
   end

   assign q_push = accept && req_last_byte;

   always_comb begin
      q_entry.overlong     = count_in > MaxCount;
      q_entry.started      = pfail_in || (ppos_in != 3'd0);
      q_entry.prefix_ok    = !pfail_in && (ppos_in == PREFIX_LEN);
      q_entry.comma        = comma_in;
      q_entry.dash_count   = dash_in;
      q_entry.first_value  = fval_in;
      q_entry.first_seen   = fseen_in;
      q_entry.first_bad    = fbad_in;
      q_entry.second_value = sval_in;
      q_entry.second_seen  = sseen_in;
      q_entry.second_bad   = sbad_in;
      q_entry.total        = req_total_size;
   end

   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         count_ff <= '0;
         ppos_ff  <= '0;
         pfail_ff <= 1'b0;
         dash_ff  <= DASH_NONE;
         comma_ff <= 1'b0;
         pend_ff  <= 1'b0;
         fval_ff  <= '0;
         fseen_ff <= 1'b0;
         fbad_ff  <= 1'b0;
         sval_ff  <= '0;
         sseen_ff <= 1'b0;
         sbad_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ppos_ff  <= ppos_in;
         pfail_ff <= pfail_in;
         dash_ff  <= dash_in;
         comma_ff <= comma_in;
         pend_ff  <= pend_in;
         fval_ff  <= fval_in;
         fseen_ff <= fseen_in;
         fbad_ff  <= fbad_in;
         sval_ff  <= sval_in;
         sseen_ff <= sseen_in;
         sbad_ff  <= sbad_in;
      end
   end

endmodule

[rtl/hbrp_queue.sv]
module hbrp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hbrp_pkg::entry_type push_entry,
   output logic                full,
   output logic                head_valid,
   output hbrp_pkg::entry_type head_entry,
   input  logic                pop
);
   import hbrp_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;

   assign full       = count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/hbrp_back.sv]
module hbrp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  hbrp_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_range_status,
   output logic [63:0]         rsp_range_start,
   output logic [63:0]         rsp_range_length
);
   import hbrp_pkg::*;

   // classify stage
   logic        a_v_ff;
   logic [1:0]  a_status_ff;
   logic        a_suffix_ff;
   logic [63:0] a_first_ff;
   logic [63:0] a_total_ff;
   logic [63:0] a_x_ff;
   // output stage
   logic        out_v_ff;
   logic [1:0]  status_ff;
   logic [63:0] start_ff;
   logic [63:0] length_ff;

   logic        b_ready, a_ready;
   logic        c_ft, c_sf, c_st, c_se;
   logic [64:0] sp1;
   logic [1:0]  status_in;
   logic        suffix_in;
   logic [63:0] x_in;
   logic [63:0] minuend, subtrahend, diff;

   assign b_ready = !out_v_ff || !rsp_stall;
   assign a_ready = !a_v_ff || b_ready;
   assign q_pop   = q_valid && a_ready;

   assign c_ft = q_entry.first_value >= q_entry.total;
   assign c_sf = q_entry.second_value < q_entry.first_value;
   assign c_st = q_entry.second_value < q_entry.total;
   assign sp1  = {1'b0, q_entry.second_value} + 65'd1;
   assign c_se = sp1 < {1'b0, q_entry.total};

   always_comb begin
      suffix_in = 1'b0;
      if (q_entry.overlong || !q_entry.started) begin
         status_in = ST_NONE;
      end else if (!q_entry.prefix_ok) begin
         status_in = ST_INVALID;
      end else if (q_entry.comma || q_entry.dash_count != DASH_ONE) begin
         status_in = ST_INVALID;
      end else if (q_entry.total == 64'd0) begin
         status_in = ST_UNSAT;
      end else if (!q_entry.first_seen) begin
         suffix_in = 1'b1;
         if (!q_entry.second_seen || q_entry.second_bad || q_entry.second_value == 64'd0) begin
            status_in = ST_INVALID;
         end else begin
            status_in = ST_VALID;
         end
      end else if (q_entry.first_bad) begin
         status_in = ST_INVALID;
      end else if (c_ft) begin
         status_in = ST_UNSAT;
      end else if (q_entry.second_seen && (q_entry.second_bad || c_sf)) begin
         status_in = ST_UNSAT;
      end else begin
         status_in = ST_VALID;
      end
      // suffix: clamped count; range: end + 1 clamped to the file size
      if (suffix_in) begin
         x_in = c_st ? q_entry.second_value : q_entry.total;
      end else begin
         x_in = (q_entry.second_seen && c_se) ? sp1[63:0] : q_entry.total;
      end
   end

   assign minuend    = a_suffix_ff ? a_total_ff : a_x_ff;
   assign subtrahend = a_suffix_ff ? a_x_ff : a_first_ff;
   assign diff       = minuend - subtrahend;

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_status_ff <= status_in;
         a_suffix_ff <= suffix_in;
         a_first_ff  <= q_entry.first_value;
         a_total_ff  <= q_entry.total;
         a_x_ff      <= x_in;
      end
      if (b_ready) begin
         status_ff <= a_status_ff;
         if (a_status_ff != ST_VALID) begin
            start_ff  <= '0;
            length_ff <= '0;
         end else if (a_suffix_ff) begin
            start_ff  <= diff;
            length_ff <= a_x_ff;
         end else begin
            start_ff  <= a_first_ff;
            length_ff <= diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_v_ff <= q_valid;
         end
         if (b_ready) begin
            out_v_ff <= a_v_ff;
         end
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_range_status = status_ff;
   assign rsp_range_start  = start_ff;
   assign rsp_range_length = length_ff;

endmodule

[rtl/hbrp_checker.sv]
module hbrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_range_status,
   input logic [63:0] rsp_range_start,
   input logic [63:0] rsp_range_length
);
   import hbrp_pkg::*;

   logic [64:0] range_end;
   assign range_end = {1'b0, rsp_range_start} + {1'b0, rsp_range_length};

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_range_status)
         && $stable(rsp_range_start) && $stable(rsp_range_length))
      else $error("stalled result changed");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status != ST_VALID |->
         rsp_range_start == 64'd0 && rsp_range_length == 64'd0)
      else $error("non-valid status with nonzero range");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status == ST_VALID |->
         rsp_range_length != 64'd0 && range_end[64:0] <= {1'b1, 64'd0})
      else $error("valid range empty or past 2^64");

endmodule

bind http_byte_range_parser_core hbrp_checker u_hbrp_checker (.*);
